@@ rtl/json_byte_validator_core_macros.svh @@
// Assertion macros used by the validator's checker.
`ifndef JSON_BYTE_VALIDATOR_CORE_MACROS_SVH
`define JSON_BYTE_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JBV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jbv: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JBV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jbv: next-cycle check failed");

`endif

@@ rtl/jbv_pkg.sv @@
// Types, constants and character helpers for the JSON byte validator.
`default_nettype none

package jbv_pkg;

  localparam int unsigned DEF_MAX_DEPTH = 64;

  // Characters used by the grammar
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = "\"";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_ONE    = "1";
  localparam logic [7:0] CH_NINE   = "9";

  typedef enum logic [1:0] {
    CMD_FEED    = 2'd0,
    CMD_PROBE   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    EX_VALUE          = 3'd0,
    EX_ARR_VAL_OR_END = 3'd1,
    EX_KEY_OR_END     = 3'd2,
    EX_KEY            = 3'd3,
    EX_COLON          = 3'd4,
    EX_OBJ_NEXT       = 3'd5,
    EX_ARR_NEXT       = 3'd6,
    EX_END            = 3'd7
  } expect_e;

  typedef enum logic [2:0] {
    SC_NONE = 3'd0,
    SC_STR  = 3'd1,
    SC_ESC  = 3'd2,
    SC_HEX  = 3'd3,
    SC_LIT  = 3'd4,
    SC_NUM  = 3'd5
  } scalar_e;

  typedef enum logic [2:0] {
    NP_SIGN       = 3'd0,
    NP_INT_ZERO   = 3'd1,
    NP_INT_DIGITS = 3'd2,
    NP_FRAC_DOT   = 3'd3,
    NP_FRAC_DIGITS = 3'd4,
    NP_EXP_START  = 3'd5,
    NP_EXP_SIGN   = 3'd6,
    NP_EXP_DIGITS = 3'd7
  } nphase_e;

  typedef enum logic [1:0] {
    LIT_TRUE  = 2'd0,
    LIT_FALSE = 2'd1,
    LIT_NULL  = 2'd2
  } lit_e;

  // Input and result words
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic       complete;
    logic [6:0] nest_level;
  } out_word_t;

  // Scalar grammar state; top_kind caches the innermost container (1 = object)
  typedef struct packed {
    expect_e    expect_mode;
    scalar_e    scalar_kind;
    nphase_e    number_phase;
    logic [2:0] hex_left;
    lit_e       literal_which;
    logic [2:0] literal_pos;
    logic       in_key;
    logic       top_kind;
  } gstate_t;

  localparam gstate_t GSTATE_RESET = '{
    expect_mode:   EX_VALUE,
    scalar_kind:   SC_NONE,
    number_phase:  NP_SIGN,
    hex_left:      3'd0,
    literal_which: LIT_TRUE,
    literal_pos:   3'd0,
    in_key:        1'b0,
    top_kind:      1'b0
  };

  // Stack write request from the grammar to the kind memory
  typedef struct packed {
    logic push;
    logic kind;
  } stack_op_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_dig(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_hexd(logic [7:0] b);
    return is_dig(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

  function automatic logic terminable(nphase_e p);
    return (p == NP_INT_ZERO) || (p == NP_INT_DIGITS) ||
           (p == NP_FRAC_DIGITS) || (p == NP_EXP_DIGITS);
  endfunction

  function automatic logic [2:0] lit_len(lit_e w);
    logic [2:0] n;
    unique case (w)
      LIT_TRUE:  n = 3'd4;
      LIT_FALSE: n = 3'd5;
      LIT_NULL:  n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] lit_char(lit_e w, logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (w)
      LIT_TRUE: begin
        unique case (pos)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (pos)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_NULL: begin
        unique case (pos)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Closed top-level value, or a bare top-level number that may end here
  function automatic logic is_complete(gstate_t s, logic lvl_zero);
    return (s.expect_mode == EX_END) ||
           (lvl_zero && (s.scalar_kind == SC_NUM) && terminable(s.number_phase));
  endfunction

endpackage

`default_nettype wire

@@ rtl/json_byte_validator_core.sv @@
// Top level of the streaming JSON byte validator.
//
//   channel   direction   handshake                 word
//   in        to core     in_valid_i / in_ready_o   in_word_t: cmd, data_byte
//   out       from core   out_valid_o / out_ready_i out_word_t: accepted, complete, nest_level
//   cfg       to core     cfg_we_i                  cfg_wdata_i: allow_whitespace
//
// One byte per cycle while the output is not stalled; its result is registered into the
// output register on accept. The container-kind memory is read every cycle at the entry
// below the new top, so a close never waits.
// Reset needs no clearing pass: only entries below the stack level are ever used.
// A stalled output word holds the input off; no more than one word is ever held.
`default_nettype none

module json_byte_validator_core
  import jbv_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic          ws_q;
  gstate_t       st_q, st_d;
  logic [LW-1:0] level_q, level_d;
  logic [LW-1:0] lvl_below;
  logic          second_q;
  logic          kind_mem [MAX_DEPTH];

  logic          g_ok;
  gstate_t       g_st;
  logic [LW-1:0] g_level;
  stack_op_t     g_stk;

  logic          accept, restart, commit;
  logic          out_valid_q;
  out_word_t     out_word_q, out_word_d;

  // Handshake: accept whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign restart    = (in_word_i.cmd == CMD_RESTART);
  assign commit     = accept && (in_word_i.cmd == CMD_FEED) && g_ok;

  jbv_grammar #(
    .MAX_DEPTH (MAX_DEPTH),
    .LW        (LW)
  ) u_grammar (
    .st_i          (st_q),
    .level_i       (level_q),
    .second_kind_i (second_q),
    .byte_i        (in_word_i.data_byte),
    .ws_en_i       (ws_q),
    .ok_o          (g_ok),
    .st_o          (g_st),
    .level_o       (g_level),
    .stk_o         (g_stk)
  );

  // Next grammar state
  always_comb begin
    st_d    = st_q;
    level_d = level_q;
    if (accept && restart) begin
      st_d    = GSTATE_RESET;
      level_d = '0;
    end else if (commit) begin
      st_d    = g_st;
      level_d = g_level;
    end
  end

  // Result word reports the state held after the step
  always_comb begin
    out_word_d.accepted   = restart ? 1'b1 : g_ok;
    out_word_d.complete   = is_complete(st_d, level_d == '0);
    out_word_d.nest_level = 7'(level_d);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= 1'b1;
      st_q        <= GSTATE_RESET;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) ws_q <= cfg_wdata_i;
      st_q    <= st_d;
      level_q <= level_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (accept) out_word_q <= out_word_d;
  end

  // Kind memory: push writes the new top, read prefetches the entry below the next top
  assign lvl_below = level_d - LW'(2);

  always_ff @(posedge clk_i) begin
    if (commit && g_stk.push) kind_mem[level_q[AW-1:0]] <= g_stk.kind;
    second_q <= kind_mem[lvl_below[AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

@@ rtl/jbv_grammar.sv @@
// Next-state logic of the JSON grammar for one byte.
`default_nettype none

module jbv_grammar
  import jbv_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DEF_MAX_DEPTH,
  parameter int unsigned LW        = $clog2(DEF_MAX_DEPTH + 1)
) (
  input  gstate_t         st_i,
  input  logic [LW-1:0]   level_i,
  input  logic            second_kind_i,
  input  logic [7:0]      byte_i,
  input  logic            ws_en_i,
  output logic            ok_o,
  output gstate_t         st_o,
  output logic [LW-1:0]   level_o,
  output stack_op_t       stk_o
);

  typedef struct packed {
    logic          ok;
    gstate_t       st;
    logic [LW-1:0] lvl;
    stack_op_t     stk;
  } step_t;

  typedef struct packed {
    logic    ok;
    nphase_e phase;
  } nx_t;

  // After a value ends: top level is done, else expect a separator
  function automatic gstate_t value_done(gstate_t s, logic [LW-1:0] lvl);
    gstate_t r;
    r = s;
    if (lvl == '0) begin
      r.expect_mode = EX_END;
    end else begin
      r.expect_mode = s.top_kind ? EX_OBJ_NEXT : EX_ARR_NEXT;
    end
    return r;
  endfunction

  function automatic step_t open_c(step_t t, logic is_obj);
    step_t r;
    r = t;
    if (t.lvl == LW'(MAX_DEPTH)) begin
      r.ok = 1'b0;
    end else begin
      r.ok             = 1'b1;
      r.stk.push       = 1'b1;
      r.stk.kind       = is_obj;
      r.st.top_kind    = is_obj;
      r.lvl            = t.lvl + LW'(1);
      r.st.expect_mode = is_obj ? EX_KEY_OR_END : EX_ARR_VAL_OR_END;
    end
    return r;
  endfunction

  // Pop: the entry below the top becomes the new top
  function automatic step_t close_c(step_t t, logic second);
    step_t r;
    r = t;
    if (t.lvl == '0) begin
      r.ok = 1'b0;
    end else begin
      r.ok          = 1'b1;
      r.lvl         = t.lvl - LW'(1);
      r.st.top_kind = second;
      r.st          = value_done(r.st, r.lvl);
    end
    return r;
  endfunction

  function automatic step_t start_value(step_t t, logic [7:0] b);
    step_t r;
    r    = t;
    r.ok = 1'b1;
    unique case (b)
      CH_QUOTE: begin
        r.st.scalar_kind = SC_STR;
        r.st.in_key      = 1'b0;
      end
      CH_LBRACE: r = open_c(t, 1'b1);
      CH_LBRACK: r = open_c(t, 1'b0);
      "t": begin
        r.st.scalar_kind   = SC_LIT;
        r.st.literal_which = LIT_TRUE;
        r.st.literal_pos   = 3'd1;
      end
      "f": begin
        r.st.scalar_kind   = SC_LIT;
        r.st.literal_which = LIT_FALSE;
        r.st.literal_pos   = 3'd1;
      end
      "n": begin
        r.st.scalar_kind   = SC_LIT;
        r.st.literal_which = LIT_NULL;
        r.st.literal_pos   = 3'd1;
      end
      CH_MINUS: begin
        r.st.scalar_kind  = SC_NUM;
        r.st.number_phase = NP_SIGN;
      end
      CH_ZERO: begin
        r.st.scalar_kind  = SC_NUM;
        r.st.number_phase = NP_INT_ZERO;
      end
      default: begin
        if ((b >= CH_ONE) && (b <= CH_NINE)) begin
          r.st.scalar_kind  = SC_NUM;
          r.st.number_phase = NP_INT_DIGITS;
        end else begin
          r.ok = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // Structural bytes and whitespace outside any scalar
  function automatic step_t between(step_t t, logic [7:0] b, logic second, logic ws);
    step_t r;
    r    = t;
    r.ok = 1'b0;
    if (is_ws(b)) begin
      r.ok = ws;
    end else begin
      unique case (t.st.expect_mode)
        EX_VALUE: r = start_value(t, b);
        EX_ARR_VAL_OR_END: begin
          if (b == CH_RBRACK) r = close_c(t, second);
          else r = start_value(t, b);
        end
        EX_KEY_OR_END, EX_KEY: begin
          if ((t.st.expect_mode == EX_KEY_OR_END) && (b == CH_RBRACE)) begin
            r = close_c(t, second);
          end else if (b == CH_QUOTE) begin
            r.ok             = 1'b1;
            r.st.scalar_kind = SC_STR;
            r.st.in_key      = 1'b1;
          end
        end
        EX_COLON: begin
          if (b == CH_COLON) begin
            r.ok             = 1'b1;
            r.st.expect_mode = EX_VALUE;
          end
        end
        EX_OBJ_NEXT: begin
          if (b == CH_COMMA) begin
            r.ok             = 1'b1;
            r.st.expect_mode = EX_KEY;
          end else if (b == CH_RBRACE) begin
            r = close_c(t, second);
          end
        end
        EX_ARR_NEXT: begin
          if (b == CH_COMMA) begin
            r.ok             = 1'b1;
            r.st.expect_mode = EX_VALUE;
          end else if (b == CH_RBRACK) begin
            r = close_c(t, second);
          end
        end
        EX_END: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Number automaton
  function automatic nx_t num_ext(nphase_e p, logic [7:0] b);
    nx_t  r;
    logic is_e;
    is_e    = (b == "e") || (b == "E");
    r.ok    = 1'b0;
    r.phase = p;
    unique case (p)
      NP_SIGN: begin
        if (b == CH_ZERO) begin
          r.ok = 1'b1; r.phase = NP_INT_ZERO;
        end else if ((b >= CH_ONE) && (b <= CH_NINE)) begin
          r.ok = 1'b1; r.phase = NP_INT_DIGITS;
        end
      end
      NP_INT_ZERO, NP_INT_DIGITS: begin
        if ((p == NP_INT_DIGITS) && is_dig(b)) begin
          r.ok = 1'b1;
        end else if (b == CH_DOT) begin
          r.ok = 1'b1; r.phase = NP_FRAC_DOT;
        end else if (is_e) begin
          r.ok = 1'b1; r.phase = NP_EXP_START;
        end
      end
      NP_FRAC_DOT: begin
        if (is_dig(b)) begin
          r.ok = 1'b1; r.phase = NP_FRAC_DIGITS;
        end
      end
      NP_FRAC_DIGITS: begin
        if (is_dig(b)) begin
          r.ok = 1'b1;
        end else if (is_e) begin
          r.ok = 1'b1; r.phase = NP_EXP_START;
        end
      end
      NP_EXP_START: begin
        if ((b == CH_PLUS) || (b == CH_MINUS)) begin
          r.ok = 1'b1; r.phase = NP_EXP_SIGN;
        end else if (is_dig(b)) begin
          r.ok = 1'b1; r.phase = NP_EXP_DIGITS;
        end
      end
      NP_EXP_SIGN: begin
        if (is_dig(b)) begin
          r.ok = 1'b1; r.phase = NP_EXP_DIGITS;
        end
      end
      NP_EXP_DIGITS: r.ok = is_dig(b);
    endcase
    return r;
  endfunction

  step_t step;
  nx_t   nx;

  // One byte through the scalar-level dispatch
  always_comb begin
    step.ok  = 1'b0;
    step.st  = st_i;
    step.lvl = level_i;
    step.stk = '0;
    nx       = num_ext(st_i.number_phase, byte_i);
    unique case (st_i.scalar_kind)
      SC_NONE: step = between(step, byte_i, second_kind_i, ws_en_i);
      SC_STR: begin
        if (byte_i == CH_QUOTE) begin
          step.ok             = 1'b1;
          step.st.scalar_kind = SC_NONE;
          if (st_i.in_key) begin
            step.st.in_key      = 1'b0;
            step.st.expect_mode = EX_COLON;
          end else begin
            step.st = value_done(step.st, step.lvl);
          end
        end else if (byte_i == CH_BSLASH) begin
          step.ok             = 1'b1;
          step.st.scalar_kind = SC_ESC;
        end else begin
          step.ok = (byte_i >= CH_SPACE);
        end
      end
      SC_ESC: begin
        if ((byte_i == CH_QUOTE) || (byte_i == CH_BSLASH) || (byte_i == CH_SLASH) ||
            (byte_i == "b") || (byte_i == "f") || (byte_i == "n") ||
            (byte_i == "r") || (byte_i == "t")) begin
          step.ok             = 1'b1;
          step.st.scalar_kind = SC_STR;
        end else if (byte_i == "u") begin
          step.ok             = 1'b1;
          step.st.scalar_kind = SC_HEX;
          step.st.hex_left    = 3'd4;
        end
      end
      SC_HEX: begin
        if (is_hexd(byte_i)) begin
          step.ok = 1'b1;
          if (st_i.hex_left <= 3'd1) begin
            step.st.hex_left    = 3'd0;
            step.st.scalar_kind = SC_STR;
          end else begin
            step.st.hex_left = st_i.hex_left - 3'd1;
          end
        end
      end
      SC_LIT: begin
        if ((st_i.literal_pos < lit_len(st_i.literal_which)) &&
            (byte_i == lit_char(st_i.literal_which, st_i.literal_pos))) begin
          step.ok             = 1'b1;
          step.st.literal_pos = st_i.literal_pos + 3'd1;
          if (step.st.literal_pos == lit_len(st_i.literal_which)) begin
            step.st.scalar_kind = SC_NONE;
            step.st             = value_done(step.st, step.lvl);
          end
        end
      end
      SC_NUM: begin
        if (nx.ok) begin
          step.ok              = 1'b1;
          step.st.number_phase = nx.phase;
        end else if (terminable(st_i.number_phase)) begin
          // number ends here; the byte is judged as a token that follows it
          step.st.scalar_kind = SC_NONE;
          step.st             = value_done(step.st, step.lvl);
          step                = between(step, byte_i, second_kind_i, ws_en_i);
        end
      end
      default: step.ok = 1'b0;
    endcase
  end

  assign ok_o    = step.ok;
  assign st_o    = step.st;
  assign level_o = step.lvl;
  assign stk_o   = step.stk;

endmodule

`default_nettype wire

@@ rtl/jbv_checker.sv @@
// Port-level checks for the JSON byte validator, bound to the top level.
`default_nettype none
`include "json_byte_validator_core_macros.svh"

module jbv_checker
  import jbv_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  logic in_fire;
  logic out_stall;
  logic restart_fire;
  logic empty_doc;

  // handshake events as seen on the ports
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_stall    = out_valid_o && !out_ready_i;
  assign restart_fire = in_fire && (in_word_i.cmd == CMD_RESTART);
  assign empty_doc    = out_word_o.accepted && !out_word_o.complete &&
                        (out_word_o.nest_level == '0);

  // stalled result word stays put
  `JBV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word_o))

  // a stalled word blocks the input side
  `JBV_ASSERT_NOW(a_stall_blocks_in, clk_i, rst_ni, out_stall, !in_ready_o)

  // every accepted word yields a result next cycle
  `JBV_ASSERT_NEXT(a_accept_gives_word, clk_i, rst_ni, in_fire, out_valid_o)

  // restart always reports an accepted, empty, incomplete document
  `JBV_ASSERT_NEXT(a_restart_word, clk_i, rst_ni, restart_fire, empty_doc)

endmodule

bind json_byte_validator_core jbv_checker u_jbv_checker (.*);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for json_byte_validator_core: directed and random JSON streams.
`timescale 1ns / 100ps

module tb_top
  import jbv_pkg::*;
();

  localparam int DEPTH = DEF_MAX_DEPTH;
  localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, behaves as a probe
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  // Predictor view of the grammar; the container kinds live in a separate vector
  typedef struct packed {
    expect_e    mode;
    scalar_e    kind;
    nphase_e    phase;
    logic [2:0] hex_left;
    lit_e       lit;
    logic [2:0] lit_pos;
    logic       in_key;
    logic [6:0] level;
  } parse_st_t;

  localparam parse_st_t PARSE_IDLE = '{
    mode:     EX_VALUE,
    kind:     SC_NONE,
    phase:    NP_SIGN,
    hex_left: 3'd0,
    lit:      LIT_TRUE,
    lit_pos:  3'd0,
    in_key:   1'b0,
    level:    7'd0
  };

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // Predictor state
  parse_st_t          doc_st = PARSE_IDLE;
  logic [DEPTH-1:0]   ctr_kinds = '0;     // 1 = object, 0 = array
  logic               ws_allowed = 1'b1;

  out_word_t verdict_q[$];
  int        mismatches = 0;
  int        words_sent = 0;

  // Traffic shaping
  logic        tx_idle_on = 1'b0;
  int          burst_left = 0;
  int          rx_mode = RX_ALWAYS;
  logic [15:0] stall_pat = '1;
  int          stall_left = 0;

  json_byte_validator_core #(.MAX_DEPTH(DEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Grammar predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0A, 8'h0D};
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hex_char(input logic [7:0] b);
    return is_numeral(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic num_can_end(input nphase_e p);
    return p inside {NP_INT_ZERO, NP_INT_DIGITS, NP_FRAC_DIGITS, NP_EXP_DIGITS};
  endfunction

  function automatic string lit_spelled(input lit_e w);
    case (w)
      LIT_TRUE:  return "true";
      LIT_FALSE: return "false";
      default:   return "null";
    endcase
  endfunction

  // A value just closed: continue in the enclosing container or finish the document
  function automatic void after_value(inout parse_st_t s);
    if (s.level == 0) begin
      s.mode = EX_END;
    end else if (ctr_kinds[s.level - 1]) begin
      s.mode = EX_OBJ_NEXT;
    end else begin
      s.mode = EX_ARR_NEXT;
    end
  endfunction

  function automatic logic push_level(inout parse_st_t s, input logic obj);
    if (s.level >= DEPTH) return 1'b0;
    ctr_kinds[s.level] = obj;     // above the committed top, harmless on a probe
    s.level = s.level + 7'd1;
    if (obj) begin
      s.mode = EX_KEY_OR_END;
    end else begin
      s.mode = EX_ARR_VAL_OR_END;
    end
    return 1'b1;
  endfunction

  function automatic logic pop_level(inout parse_st_t s);
    if (s.level == 0) return 1'b0;
    s.level = s.level - 7'd1;
    after_value(s);
    return 1'b1;
  endfunction

  function automatic logic start_value(inout parse_st_t s, input logic [7:0] b);
    case (b)
      "\"": begin
        s.kind = SC_STR;
        s.in_key = 1'b0;
        return 1'b1;
      end
      "{": return push_level(s, 1'b1);
      "[": return push_level(s, 1'b0);
      "t", "f", "n": begin
        s.kind = SC_LIT;
        s.lit_pos = 3'd1;
        if (b == "t") begin
          s.lit = LIT_TRUE;
        end else if (b == "f") begin
          s.lit = LIT_FALSE;
        end else begin
          s.lit = LIT_NULL;
        end
        return 1'b1;
      end
      "-": begin
        s.kind = SC_NUM;
        s.phase = NP_SIGN;
        return 1'b1;
      end
      "0": begin
        s.kind = SC_NUM;
        s.phase = NP_INT_ZERO;
        return 1'b1;
      end
      default: begin
        if (b >= "1" && b <= "9") begin
          s.kind = SC_NUM;
          s.phase = NP_INT_DIGITS;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Byte outside any scalar: punctuation, whitespace or the start of a value
  function automatic logic token_byte(inout parse_st_t s, input logic [7:0] b);
    if (is_blank(b)) return ws_allowed;
    case (s.mode)
      EX_VALUE: return start_value(s, b);
      EX_ARR_VAL_OR_END: begin
        if (b == "]") return pop_level(s);
        return start_value(s, b);
      end
      EX_KEY_OR_END, EX_KEY: begin
        if (b == "}" && s.mode == EX_KEY_OR_END) return pop_level(s);
        if (b == "\"") begin
          s.kind = SC_STR;
          s.in_key = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      EX_COLON: begin
        if (b != ":") return 1'b0;
        s.mode = EX_VALUE;
        return 1'b1;
      end
      EX_OBJ_NEXT: begin
        if (b == "}") return pop_level(s);
        if (b != ",") return 1'b0;
        s.mode = EX_KEY;
        return 1'b1;
      end
      EX_ARR_NEXT: begin
        if (b == "]") return pop_level(s);
        if (b != ",") return 1'b0;
        s.mode = EX_VALUE;
        return 1'b1;
      end
      default: return 1'b0;   // only whitespace after the top-level value
    endcase
  endfunction

  // Number automaton; 0 means the byte does not extend the number
  function automatic logic number_step(inout parse_st_t s, input logic [7:0] b);
    logic exp_mark;
    exp_mark = (b == "e") || (b == "E");
    case (s.phase)
      NP_SIGN: begin
        if (b == "0") begin
          s.phase = NP_INT_ZERO;
          return 1'b1;
        end
        if (b >= "1" && b <= "9") begin
          s.phase = NP_INT_DIGITS;
          return 1'b1;
        end
        return 1'b0;
      end
      NP_INT_ZERO, NP_INT_DIGITS: begin
        if (s.phase == NP_INT_DIGITS && is_numeral(b)) return 1'b1;
        if (b == ".") begin
          s.phase = NP_FRAC_DOT;
          return 1'b1;
        end
        if (exp_mark) begin
          s.phase = NP_EXP_START;
          return 1'b1;
        end
        return 1'b0;
      end
      NP_FRAC_DOT: begin
        if (!is_numeral(b)) return 1'b0;
        s.phase = NP_FRAC_DIGITS;
        return 1'b1;
      end
      NP_FRAC_DIGITS: begin
        if (is_numeral(b)) return 1'b1;
        if (!exp_mark) return 1'b0;
        s.phase = NP_EXP_START;
        return 1'b1;
      end
      NP_EXP_START: begin
        if (b == "+" || b == "-") begin
          s.phase = NP_EXP_SIGN;
          return 1'b1;
        end
        if (!is_numeral(b)) return 1'b0;
        s.phase = NP_EXP_DIGITS;
        return 1'b1;
      end
      NP_EXP_SIGN: begin
        if (!is_numeral(b)) return 1'b0;
        s.phase = NP_EXP_DIGITS;
        return 1'b1;
      end
      default: return is_numeral(b);
    endcase
  endfunction

  function automatic logic consume(inout parse_st_t s, input logic [7:0] b);
    string spell;
    case (s.kind)
      SC_NONE: return token_byte(s, b);
      SC_STR: begin
        if (b == "\"") begin
          s.kind = SC_NONE;
          if (s.in_key) begin
            s.in_key = 1'b0;
            s.mode = EX_COLON;
          end else begin
            after_value(s);
          end
          return 1'b1;
        end
        if (b == "\\") begin
          s.kind = SC_ESC;
          return 1'b1;
        end
        return b >= 8'h20;
      end
      SC_ESC: begin
        case (b)
          "\"", "\\", "/", "b", "f", "n", "r", "t": begin
            s.kind = SC_STR;
            return 1'b1;
          end
          "u": begin
            s.kind = SC_HEX;
            s.hex_left = 3'd4;
            return 1'b1;
          end
          default: return 1'b0;
        endcase
      end
      SC_HEX: begin
        if (!is_hex_char(b)) return 1'b0;
        if (s.hex_left <= 3'd1) begin
          s.hex_left = 3'd0;
          s.kind = SC_STR;
        end else begin
          s.hex_left = s.hex_left - 3'd1;
        end
        return 1'b1;
      end
      SC_LIT: begin
        spell = lit_spelled(s.lit);
        if (int'(s.lit_pos) >= spell.len()) return 1'b0;
        if (b != spell[s.lit_pos]) return 1'b0;
        s.lit_pos = s.lit_pos + 3'd1;
        if (int'(s.lit_pos) == spell.len()) begin
          s.kind = SC_NONE;
          after_value(s);
        end
        return 1'b1;
      end
      SC_NUM: begin
        if (number_step(s, b)) return 1'b1;
        if (!num_can_end(s.phase)) return 1'b0;
        // the byte ends the number and is then taken as a token
        s.kind = SC_NONE;
        after_value(s);
        return token_byte(s, b);
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic doc_done(input parse_st_t s);
    return (s.mode == EX_END) || (s.level == 0 && s.kind == SC_NUM && num_can_end(s.phase));
  endfunction

  // Expected result word for one accepted input word; commits the state on a good feed
  function automatic out_word_t judge_byte(input logic [1:0] c, input logic [7:0] b);
    parse_st_t trial;
    logic      ok;
    out_word_t r;
    ok = 1'b1;
    if (c == CMD_RESTART) begin
      doc_st = PARSE_IDLE;
    end else begin
      trial = doc_st;
      ok = consume(trial, b);
      if (ok && c == CMD_FEED) doc_st = trial;
    end
    r.accepted = ok;
    r.complete = doc_done(doc_st);
    r.nest_level = doc_st.level;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result word %h at %0t with nothing pending", out_word, $realtime);
      end else begin
        want = verdict_q.pop_front();
        check_field("accepted", 7'(want.accepted), 7'(out_word.accepted));
        check_field("complete", 7'(want.complete), 7'(out_word.complete));
        check_field("nest_level", want.nest_level, out_word.nest_level);
      end
    end
  end

  // Receiver back-pressure: a 16-bit ready pattern, redrawn per mode once used up
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case (rx_mode)
        RX_ALWAYS: stall_pat = '1;
        RX_RANDOM: stall_pat = 16'($urandom);
        default:   stall_pat = 16'($urandom & $urandom);
      endcase
      stall_left = 16;
    end
    out_ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    stall_left--;
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one input word; valid stays high afterwards so back-to-back words need no drop
  task automatic send_word(input logic [1:0] c, input logic [7:0] b);
    int gap;
    if (tx_idle_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b1;
    in_word <= {c, b};
    do @(posedge clk_i); while (!in_ready);
    verdict_q.insert(verdict_q.size(), judge_byte(c, b));
    words_sent++;
  endtask

  // Hold off input until every pending result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_whitespace(input logic v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    ws_allowed = v;
  endtask

  task automatic feed_text(input string t);
    for (int i = 0; i < t.len(); i++) send_word(CMD_FEED, t[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Document generation
  // ---------------------------------------------------------------------------

  function automatic string chr(input logic [7:0] c);
    string t;
    t = "?";
    t[0] = c;
    return t;
  endfunction

  function automatic string gen_space();
    string s;
    int    n;
    s = "";
    if (!ws_allowed || $urandom_range(0, 2) != 0) return s;
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: s = {s, " "};
        1: s = {s, chr(8'h09)};
        2: s = {s, chr(8'h0A)};
        default: s = {s, chr(8'h0D)};
      endcase
    end
    return s;
  endfunction

  function automatic string gen_digits(input int lo, input int hi);
    string s;
    int    n;
    s = "";
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) s = {s, chr(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string gen_number();
    string s;
    s = "";
    if ($urandom_range(0, 2) == 0) s = "-";
    if ($urandom_range(0, 3) == 0) begin
      s = {s, "0"};
    end else begin
      s = {s, chr(8'("1" + $urandom_range(0, 8))), gen_digits(0, 3)};
    end
    if ($urandom_range(0, 2) == 0) s = {s, ".", gen_digits(1, 3)};
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1) != 0) begin
        s = {s, "e"};
      end else begin
        s = {s, "E"};
      end
      case ($urandom_range(0, 2))
        0: s = {s, "+"};
        1: s = {s, "-"};
        default: s = s;
      endcase
      s = {s, gen_digits(1, 2)};
    end
    return s;
  endfunction

  // Quoted string body: plain, high-bit bytes, short escapes and \u escapes
  function automatic string gen_text();
    string       s;
    string       hexset;
    string       escset;
    logic [7:0]  c;
    int          n;
    int          pick;
    s = "";
    hexset = "0123456789abcdefABCDEF";
    escset = "\"\\/bfnrt";
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == "\"" || c == "\\");
        s = {s, chr(c)};
      end else if (pick < 70) begin
        s = {s, chr(8'($urandom_range(8'h80, 8'hFF)))};
      end else if (pick < 85) begin
        s = {s, "\\", chr(escset[$urandom_range(0, escset.len() - 1)])};
      end else begin
        s = {s, "\\u"};
        for (int k = 0; k < 4; k++) s = {s, chr(hexset[$urandom_range(0, hexset.len() - 1)])};
      end
    end
    return s;
  endfunction

  function automatic string gen_value(input int lvl);
    string s;
    int    n;
    int    pick;
    pick = $urandom_range(0, (lvl < 3) ? 7 : 3);
    case (pick)
      0: s = gen_number();
      1, 3: s = {"\"", gen_text(), "\""};
      2: begin
        case ($urandom_range(0, 2))
          0: s = "true";
          1: s = "false";
          default: s = "null";
        endcase
      end
      4, 5: begin
        s = {"[", gen_space()};
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) s = {s, ",", gen_space()};
          s = {s, gen_value(lvl + 1), gen_space()};
        end
        s = {s, "]"};
      end
      default: begin
        s = {"{", gen_space()};
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) s = {s, ",", gen_space()};
          s = {s, "\"", gen_text(), "\"", gen_space(), ":", gen_space()};
          s = {s, gen_value(lvl + 1), gen_space()};
        end
        s = {s, "}"};
      end
    endcase
    return s;
  endfunction

  // Feed a document with sprinkled probes and the odd stray byte
  task automatic feed_doc(input string d);
    int pick;
    for (int i = 0; i < d.len(); i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_word(CMD_PROBE, 8'($urandom_range(0, 255)));
      end else if (pick == 3) begin
        send_word(CMD_SPARE, 8'($urandom_range(0, 255)));
      end else if (pick == 4) begin
        send_word(CMD_FEED, 8'($urandom_range(0, 255)));
      end else if (pick == 5) begin
        send_word(CMD_PROBE, d[i]);
      end
      send_word(CMD_FEED, d[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every command, rejection, probe and trailing bytes
  task automatic test_directed();
    send_word(CMD_RESTART, 8'hFF);
    send_word(CMD_FEED, 8'h00);          // control byte where a value is due
    send_word(CMD_FEED, 8'hFF);
    send_word(CMD_PROBE, "{");           // judged, not committed
    send_word(CMD_SPARE, "[");           // spare code acts as a probe
    feed_text("-0");                     // bare number, already complete
    send_word(CMD_FEED, " ");            // ends the number
    send_word(CMD_FEED, "1");            // nothing but whitespace after the value
    send_word(CMD_FEED, 8'h0D);
    send_word(CMD_RESTART, 8'h00);
    feed_text("[1e5,\"\\uA0f9\"]");
    send_word(CMD_FEED, "]");            // extra close at level zero
  endtask

  // Compact mode: whitespace rejected between tokens, even to end a number
  task automatic test_compact_mode();
    set_whitespace(1'b0);
    send_word(CMD_RESTART, 8'h5A);
    feed_text("[1");
    send_word(CMD_FEED, " ");
    send_word(CMD_FEED, "]");
    send_word(CMD_FEED, 8'h09);
    send_word(CMD_RESTART, 8'hA5);
    feed_text("\" \"");                  // space inside a string is fine
    set_whitespace(1'b1);
  endtask

  // Fill the nesting stack, try one more level, then unwind it
  task automatic test_depth_limit();
    logic [DEPTH-1:0] opened;
    send_word(CMD_RESTART, 8'h00);
    for (int i = 0; i < DEPTH; i++) begin
      opened[i] = ($urandom_range(0, 3) == 0);
      if (opened[i]) begin
        feed_text("{\"\":");
      end else begin
        send_word(CMD_FEED, "[");
      end
    end
    send_word(CMD_FEED, "[");
    send_word(CMD_FEED, "{");
    send_word(CMD_PROBE, "[");
    send_word(CMD_FEED, "7");
    for (int i = DEPTH - 1; i >= 0; i--) send_word(CMD_FEED, opened[i] ? "}" : "]");
    send_word(CMD_RESTART, 8'h00);
  endtask

  // Unstructured words of any command and byte
  task automatic test_noise(input int n_words);
    for (int i = 0; i < n_words; i++)
      send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_docs(input int n_words, input logic ws, input logic idle,
                                  input int rx);
    int first;
    set_whitespace(ws);
    tx_idle_on = idle;
    rx_mode = rx;
    first = words_sent;
    while (words_sent - first < n_words) begin
      feed_doc({gen_space(), gen_value(0), gen_space()});
      if ($urandom_range(0, 9) != 0) send_word(CMD_RESTART, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) wait_drain();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_compact_mode();
    tx_idle_on = 1'b1;
    rx_mode = RX_RANDOM;
    test_depth_limit();
    test_noise(30);
    test_random_docs(40, 1'b1, 1'b1, RX_RANDOM);
    test_random_docs(40, 1'b0, 1'b0, RX_ALWAYS);
    test_random_docs(40, 1'b1, 1'b1, RX_SPARSE);
    test_random_docs(40, 1'b0, 1'b1, RX_RANDOM);

    wait_drain();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
